/* sv/realized_variance_tracker_unit_defines.svh */
// Assertion macros used by the RTL top file.
`ifndef REALIZED_VARIANCE_TRACKER_UNIT_DEFINES_SVH
`define REALIZED_VARIANCE_TRACKER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RVT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RVT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RVT_ASSERT(label, prop, msg)
`define RVT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* sv/rvt_pkg.sv */
package rvt_pkg;

    localparam int COUNT_BITS_DEF = 20;
    localparam int PRICE_BITS_DEF = 32;

    localparam int MUL_WIDTH = 64;
    localparam int MUL_DIGIT = 4;
    localparam int MUL_STEPS = MUL_WIDTH / MUL_DIGIT;
    localparam int DIV_WIDTH = 96;
    localparam int LOG_STEPS = 34;
    localparam int LOG_BITS  = 40;

    localparam logic [63:0] LN2_Q64      = 64'hB17217F7D1CF79AC;
    localparam logic [62:0] VAR_MAX      = 63'h7FFFFFFFFFFFFFFF;
    localparam logic [31:0] ANNUAL_RESET = 32'd16515072;
    localparam logic [19:0] TOTAL_RESET  = 20'd252;

    localparam logic [1:0] ST_RECORDED = 2'd0;
    localparam logic [1:0] ST_SEEDED   = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM,
        S_SQ_WAIT,
        S_LN_WAIT,
        S_DIFF,
        S_RET_WAIT,
        S_ACCUM,
        S_SCALE,
        S_VAR_WAIT,
        S_DIV_WAIT,
        S_EMIT
    } state_t;

endpackage

/* sv/rvt_mul.sv */
module rvt_mul (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [rvt_pkg::MUL_WIDTH-1:0]        a,
    input  logic [rvt_pkg::MUL_WIDTH-1:0]        b,
    output logic                                 done,
    output logic [2*rvt_pkg::MUL_WIDTH-1:0]      prod
);

    localparam int W  = rvt_pkg::MUL_WIDTH;
    localparam int D  = rvt_pkg::MUL_DIGIT;
    localparam int CW = $clog2(rvt_pkg::MUL_STEPS);

    logic [W-1:0]   a_reg;
    logic [W-1:0]   b_reg;
    logic [2*W-1:0] acc_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [W+D-1:0] partial;

    assign partial = (W + D)'(a_reg) * (W + D)'(b_reg[W-1 -: D]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(rvt_pkg::MUL_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= {acc_reg[2*W-D-1:0], {D{1'b0}}} + (2*W)'(partial);
            b_reg   <= {b_reg[W-D-1:0], {D{1'b0}}};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

/* sv/rvt_div.sv */
module rvt_div #(
    parameter int COUNT_BITS = rvt_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [rvt_pkg::DIV_WIDTH-1:0]  dividend,
    input  logic [COUNT_BITS-1:0]          divisor,
    output logic                           done,
    output logic [rvt_pkg::DIV_WIDTH-1:0]  quotient
);

    localparam int W  = rvt_pkg::DIV_WIDTH;
    localparam int CW = $clog2(W);

    logic [W-1:0]          dd_reg;
    logic [COUNT_BITS-1:0] dvs_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [COUNT_BITS:0]   shifted;
    logic                  q_bit;

    assign shifted = {rem_reg, dd_reg[W-1]};
    assign q_bit   = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dd_reg  <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= q_bit ? COUNT_BITS'(shifted - {1'b0, dvs_reg})
                             : shifted[COUNT_BITS-1:0];
            dd_reg  <= {dd_reg[W-2:0], q_bit};
        end
    end

    assign done     = done_reg;
    assign quotient = dd_reg;

endmodule

/* sv/realized_variance_tracker_unit.sv */
// Realized variance tracker.
// Input channel: spot_price with in_valid/in_stall; one beat per price.
// Output channel: status, realized_var, returns_done with out_valid/out_stall;
// exactly one beat per accepted price, in order.
// Configuration: APB port; annual_factor at 0x0, total_returns at 0x4.
// Flow from the accept edge to the output register: an invalid or refused
// price goes straight to the output. A seeding price runs up to 31
// normalizing shifts, a start, 34 squarings and one multiply by ln2, and
// then is stored. A recorded return adds to the log a square, an accumulate,
// a scale multiply, a divide and a store. The serial multiplier (4 bits per
// cycle) and the one-bit divider do the arithmetic; one price is worked at a
// time, and the next price is taken in the cycle after the result is loaded.
// Reset clears the accumulated state and loads annual_factor 252.0 and
// total_returns 252. While the receiver stalls, the output beat holds and the
// next price may be taken and worked; its result waits until the beat drains.
`include "realized_variance_tracker_unit_defines.svh"

module realized_variance_tracker_unit #(
    parameter int COUNT_BITS = rvt_pkg::COUNT_BITS_DEF,
    parameter int PRICE_BITS = rvt_pkg::PRICE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] spot_price,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [62:0] realized_var,
    output logic [19:0] returns_done
);

    localparam int M_SHIFT = 63 - PRICE_BITS;
    localparam int LW      = rvt_pkg::LOG_BITS;
    localparam int SW      = $clog2(rvt_pkg::LOG_STEPS);

    rvt_pkg::state_t state_reg, state_next;

    logic [31:0]           annual_reg;
    logic [19:0]           total_reg;
    logic                  have_prev_reg, have_prev_next;
    logic [LW-1:0]         prev_reg, prev_next;
    logic [63:0]           sum_reg, sum_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [62:0]           var_reg, var_next;
    logic [63:0]           m_reg, m_next;
    logic [5:0]            e_reg, e_next;
    logic [33:0]           frac_reg, frac_next;
    logic [SW-1:0]         step_reg, step_next;
    logic [LW-1:0]         cur_reg, cur_next;
    logic [63:0]           sq_reg, sq_next;
    logic [1:0]            stat_reg, stat_next;
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            out_status_reg, out_status_next;
    logic [62:0]           out_var_reg, out_var_next;
    logic [19:0]           out_done_reg, out_done_next;

    logic [PRICE_BITS-1:0] price;
    logic                  full;
    logic                  mul_start;
    logic [63:0]           mul_a;
    logic [63:0]           mul_b;
    logic                  mul_done;
    logic [127:0]          mul_prod;
    logic                  div_start;
    logic                  div_done;
    logic [95:0]           div_q;
    logic [63:0]           sq_m;
    logic [33:0]           frac_step;
    logic [63:0]           m_step;
    logic [LW-1:0]         diff;
    logic [64:0]           sum_add;
    logic                  cfg_wr;
    logic                  mul_wait;
    logic                  out_held;

    rvt_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    rvt_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_prod[95:0]),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'(total_reg) : annual_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            annual_reg <= rvt_pkg::ANNUAL_RESET;
            total_reg  <= rvt_pkg::TOTAL_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
            begin
                total_reg <= pwdata[19:0];
            end
            else
            begin
                annual_reg <= pwdata;
            end
        end
    end

    assign price     = PRICE_BITS'(spot_price);
    assign full      = (33'(count_reg) >= 33'(total_reg)) || (&count_reg);
    assign sq_m      = mul_prod[125:62];
    assign frac_step = {frac_reg[32:0], sq_m[63]};
    assign m_step    = sq_m[63] ? {1'b0, sq_m[63:1]} : sq_m;
    assign diff      = (cur_reg >= prev_reg) ? (cur_reg - prev_reg) : (prev_reg - cur_reg);
    assign sum_add   = {1'b0, sum_reg} + {1'b0, sq_reg};
    assign in_stall  = (state_reg != rvt_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rvt_pkg::S_IDLE;
            have_prev_reg <= 1'b0;
            prev_reg      <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            var_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            have_prev_reg <= have_prev_next;
            prev_reg      <= prev_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            var_reg       <= var_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg          <= m_next;
        e_reg          <= e_next;
        frac_reg       <= frac_next;
        step_reg       <= step_next;
        cur_reg        <= cur_next;
        sq_reg         <= sq_next;
        stat_reg       <= stat_next;
        out_status_reg <= out_status_next;
        out_var_reg    <= out_var_next;
        out_done_reg   <= out_done_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        have_prev_next  = have_prev_reg;
        prev_next       = prev_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        var_next        = var_reg;
        m_next          = m_reg;
        e_next          = e_reg;
        frac_next       = frac_reg;
        step_next       = step_reg;
        cur_next        = cur_reg;
        sq_next         = sq_reg;
        stat_next       = stat_reg;
        out_status_next = out_status_reg;
        out_var_next    = out_var_reg;
        out_done_next   = out_done_reg;
        out_valid_next  = out_valid_reg && out_stall;
        mul_start       = 1'b0;
        mul_a           = '0;
        mul_b           = '0;
        div_start       = 1'b0;

        unique case (state_reg)
            rvt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    m_next = 64'(price) << M_SHIFT;
                    e_next = 6'(PRICE_BITS - 1);
                    if ((price == '0) || (annual_reg == '0))
                    begin
                        stat_next  = rvt_pkg::ST_INVALID;
                        state_next = rvt_pkg::S_EMIT;
                    end
                    else if (!have_prev_reg)
                    begin
                        state_next = rvt_pkg::S_NORM;
                    end
                    else if (full)
                    begin
                        stat_next  = rvt_pkg::ST_FULL;
                        state_next = rvt_pkg::S_EMIT;
                    end
                    else
                    begin
                        state_next = rvt_pkg::S_NORM;
                    end
                end
            end
            rvt_pkg::S_NORM:
            begin
                if (m_reg[62])
                begin
                    mul_start  = 1'b1;
                    mul_a      = m_reg;
                    mul_b      = m_reg;
                    step_next  = '0;
                    frac_next  = '0;
                    state_next = rvt_pkg::S_SQ_WAIT;
                end
                else
                begin
                    m_next = {m_reg[62:0], 1'b0};
                    e_next = e_reg - 1'b1;
                end
            end
            rvt_pkg::S_SQ_WAIT:
            begin
                if (mul_done)
                begin
                    frac_next = frac_step;
                    m_next    = m_step;
                    mul_start = 1'b1;
                    if (step_reg == SW'(rvt_pkg::LOG_STEPS - 1))
                    begin
                        mul_a      = 64'({e_reg, frac_step});
                        mul_b      = rvt_pkg::LN2_Q64;
                        state_next = rvt_pkg::S_LN_WAIT;
                    end
                    else
                    begin
                        mul_a     = m_step;
                        mul_b     = m_step;
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            rvt_pkg::S_LN_WAIT:
            begin
                if (mul_done)
                begin
                    cur_next   = mul_prod[103:64] + LW'(mul_prod[63]);
                    state_next = rvt_pkg::S_DIFF;
                end
            end
            rvt_pkg::S_DIFF:
            begin
                if (!have_prev_reg)
                begin
                    prev_next      = cur_reg;
                    have_prev_next = 1'b1;
                    stat_next      = rvt_pkg::ST_SEEDED;
                    state_next     = rvt_pkg::S_EMIT;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_a      = 64'(diff);
                    mul_b      = 64'(diff);
                    state_next = rvt_pkg::S_RET_WAIT;
                end
            end
            rvt_pkg::S_RET_WAIT:
            begin
                if (mul_done)
                begin
                    sq_next    = mul_prod[91:28] + 64'(mul_prod[27]);
                    state_next = rvt_pkg::S_ACCUM;
                end
            end
            rvt_pkg::S_ACCUM:
            begin
                sum_next   = sum_add[64] ? '1 : sum_add[63:0];
                count_next = count_reg + 1'b1;
                prev_next  = cur_reg;
                state_next = rvt_pkg::S_SCALE;
            end
            rvt_pkg::S_SCALE:
            begin
                mul_start  = 1'b1;
                mul_a      = 64'(annual_reg);
                mul_b      = sum_reg;
                state_next = rvt_pkg::S_VAR_WAIT;
            end
            rvt_pkg::S_VAR_WAIT:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = rvt_pkg::S_DIV_WAIT;
                end
            end
            rvt_pkg::S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    var_next   = (|div_q[95:79]) ? rvt_pkg::VAR_MAX : div_q[78:16];
                    stat_next  = rvt_pkg::ST_RECORDED;
                    state_next = rvt_pkg::S_EMIT;
                end
            end
            rvt_pkg::S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = stat_reg;
                    out_var_next    = var_reg;
                    out_done_next   = 20'(count_reg);
                    state_next      = rvt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rvt_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign realized_var = out_var_reg;
    assign returns_done = out_done_reg;

    assign mul_wait = state_reg inside {rvt_pkg::S_SQ_WAIT, rvt_pkg::S_LN_WAIT,
                                        rvt_pkg::S_RET_WAIT, rvt_pkg::S_VAR_WAIT};
    assign out_held = out_valid_reg && out_stall;

    `RVT_ASSERT(a_mul_done_waited, mul_done |-> mul_wait, "multiplier finished outside a wait state")
    `RVT_ASSERT(a_div_done_waited, div_done |-> (state_reg == rvt_pkg::S_DIV_WAIT), "divider finished outside its wait state")
    `RVT_ASSERT(a_sum_monotonic, ##1 (sum_reg >= $past(sum_reg)), "sum of squared returns decreased")
    `RVT_ASSERT(a_seed_sticky, !$fell(have_prev_reg), "seed flag cleared outside reset")
    `RVT_ASSERT(a_hold, out_held |=> out_valid && $stable(out_var_reg), "beat changed under stall")

endmodule

/* tb/realized_variance_tracker_unit_tb.sv */
module realized_variance_tracker_unit_tb;

    localparam logic [2:0] ADDR_ANNUAL = 3'd0;
    localparam logic [2:0] ADDR_TOTAL  = 3'd4;
    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD   = 3000;

    typedef struct {
        logic [1:0]  st;
        logic [62:0] rvar;
        logic [19:0] done;
    } var_beat_t;

    class variance_scoreboard;
        logic [31:0] annual;
        logic [19:0] total;
        bit          have_prev;
        logic [39:0] prev_ln;
        logic [63:0] sum_sq;
        logic [19:0] count;
        logic [62:0] var_val;
        var_beat_t   pending[$];

        function new();
            annual = rvt_pkg::ANNUAL_RESET;
            total = rvt_pkg::TOTAL_RESET;
            have_prev = 0;
            prev_ln = '0;
            sum_sq = '0;
            count = '0;
            var_val = '0;
        endfunction

        function logic [39:0] ln_q34(logic [31:0] p);
            int e;
            logic [63:0] m;
            logic [63:0] frac;
            logic [127:0] sq;
            e = 0;
            for (int i = 0; i < 32; i++)
                if (p[i])
                    e = i;
            m = 64'(p) << (62 - e);
            frac = '0;
            for (int i = 0; i < rvt_pkg::LOG_STEPS; i++)
            begin
                sq = {64'b0, m} * {64'b0, m};
                m = sq[125:62];
                frac = frac << 1;
                if (m[63])
                begin
                    frac[0] = 1'b1;
                    m = m >> 1;
                end
            end
            sq = {64'b0, (64'(e) << 34) | frac} * {64'b0, rvt_pkg::LN2_Q64};
            return 40'(sq[127:64] + 64'(sq[63]));
        endfunction

        function void note_price(logic [31:0] price);
            var_beat_t b;
            logic [39:0] cur;
            logic [39:0] d;
            logic [127:0] wide;
            logic [63:0] sq;
            logic [64:0] s65;
            if (price == 0 || annual == 0)
                b.st = rvt_pkg::ST_INVALID;
            else if (!have_prev)
            begin
                prev_ln = ln_q34(price);
                have_prev = 1;
                b.st = rvt_pkg::ST_SEEDED;
            end
            else if (count >= total || count == 20'hFFFFF)
                b.st = rvt_pkg::ST_FULL;
            else
            begin
                cur = ln_q34(price);
                d = cur >= prev_ln ? cur - prev_ln : prev_ln - cur;
                wide = {88'b0, d} * {88'b0, d};
                sq = wide[91:28] + 64'(wide[27]);
                s65 = {1'b0, sum_sq} + {1'b0, sq};
                sum_sq = s65[64] ? '1 : s65[63:0];
                count = count + 1'b1;
                prev_ln = cur;
                wide = ({96'b0, annual} * {64'b0, sum_sq}) / {108'b0, count};
                wide = wide >> 16;
                var_val = wide > {65'b0, rvt_pkg::VAR_MAX} ? rvt_pkg::VAR_MAX : wide[62:0];
                b.st = rvt_pkg::ST_RECORDED;
            end
            b.rvar = var_val;
            b.done = count;
            pending.insert(pending.size(), b);
        endfunction

        // bit 3: no beat expected; bits 2..0: status, variance, count differ
        function logic [3:0] check_beat(var_beat_t got, output var_beat_t want);
            if (pending.size() == 0)
            begin
                want = got;
                return 4'b1000;
            end
            want = pending.pop_front();
            return {1'b0, got.st !== want.st, got.rvar !== want.rvar,
                    got.done !== want.done};
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 0;
    logic        in_stall;
    logic [31:0] spot_price = '0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [1:0]  status;
    logic [62:0] realized_var;
    logic [19:0] returns_done;

    variance_scoreboard sb = new();
    int errors = 0;
    int quiet = 0;
    bit calm = 0;
    bit hold_req = 0;
    logic [31:0] last_price = 32'd1000;

    realized_variance_tracker_unit u_top (.*);

    always #4 clk = ~clk;

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver
    initial
    begin
        int hold;
        var_beat_t got;
        var_beat_t want;
        logic [3:0] bad;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                hold = LONG_HOLD;
            end
            out_stall = hold > 0;
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (out_valid)
            begin
                got.st = status;
                got.rvar = realized_var;
                got.done = returns_done;
                bad = sb.check_beat(got, want);
                if (bad[3])
                    report("unexpected beat", 64'(got.st), 64'hX);
                if (bad[2])
                    report("status", 64'(got.st), 64'(want.st));
                if (bad[1])
                    report("realized_var", 64'(got.rvar), 64'(want.rvar));
                if (bad[0])
                    report("returns_done", 64'(got.done), 64'(want.done));
                hold = calm ? 0 : $urandom_range(0, 16);
            end
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge clk);
        psel = 1;
        penable = 0;
        pwrite = 1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == ADDR_ANNUAL)
            sb.annual = data;
        else
            sb.total = data[19:0];
        @(negedge clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    task automatic send_price(logic [31:0] price);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 16);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid = 0;
        end
        @(negedge clk);
        in_valid = 1;
        spot_price = price;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_price(price);
        @(negedge clk);
        in_valid = 0;
    endtask

    function automatic logic [31:0] pick_price();
        int k;
        logic [31:0] step;
        k = $urandom_range(0, 19);
        if (k == 0)
            return 32'd0;
        if (k <= 2)
            return $urandom;
        if (k == 3)
            return 32'd1 << $urandom_range(0, 31);
        if (k == 4)
            return $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'd1;
        step = $urandom_range(0, 1) ? (last_price >> $urandom_range(2, 12))
                                    : 32'($urandom_range(0, 64));
        if ($urandom_range(0, 1) && last_price > step)
            last_price = last_price - step;
        else if (last_price <= 32'hFFFFFFFF - step)
            last_price = last_price + step;
        if (last_price == 0)
            last_price = 32'd1;
        return last_price;
    endfunction

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_run(int n, bit with_hold);
        for (int i = 0; i < n; i++)
        begin
            calm = (i % 60) >= 45;
            if (with_hold && i == n / 2)
            begin
                calm = 1;
                hold_req = 1;
            end
            send_price(pick_price());
        end
        calm = 0;
    endtask

    initial
    begin
        logic [31:0] directed[$];
        directed = '{32'd0, 32'd1, 32'hFFFFFFFF, 32'd1, 32'h80000000, 32'h7FFFFFFF,
                     32'd2, 32'd3, 32'd0, 32'hAAAAAAAA, 32'h55555555, 32'd1000,
                     32'd1001, 32'd1001, 32'hFFFFFFFE, 32'h00010000, 32'd1};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        foreach (directed[i])
            send_price(directed[i]);
        drain();

        apb_write(ADDR_ANNUAL, 32'hFFFFFFFF);
        apb_write(ADDR_TOTAL, 32'h000FFFFF);
        random_run(150, 1);
        drain();

        apb_write(ADDR_ANNUAL, 32'd1);
        apb_write(ADDR_TOTAL, 32'(sb.count + 20'd30));
        random_run(60, 0);
        drain();

        apb_write(ADDR_ANNUAL, 32'd0);
        send_price(32'd500);
        send_price(32'd0);
        drain();
        apb_write(ADDR_ANNUAL, 32'd65536);
        apb_write(ADDR_TOTAL, 32'd0);
        send_price(32'd700);
        send_price(32'hFFFFFFFF);
        drain();

        apb_write(ADDR_ANNUAL, $urandom_range(1, 32'hFFFFFFFF));
        apb_write(ADDR_TOTAL, 32'h000FFFFF);
        random_run(150, 1);
        drain();

        apb_write(ADDR_ANNUAL, rvt_pkg::ANNUAL_RESET);
        random_run(120, 0);
        drain();

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
